// ----- hdl/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg
// Types, codes and helpers shared by the keyed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_FIND     = 3'd1;
  localparam logic [2:0] OP_DELETE   = 3'd2;
  localparam logic [2:0] OP_UPD_NAME = 3'd3;
  localparam logic [2:0] OP_UPD_AGE  = 3'd4;
  localparam logic [2:0] OP_LIST     = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] record_key;
    logic [63:0]        name_bytes_low;
    logic [63:0]        name_bytes_mid;
    logic [31:0]        name_bytes_high;
    logic [7:0]         age_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic [63:0]        out_name_low;
    logic [63:0]        out_name_mid;
    logic [31:0]        out_name_high;
    logic [7:0]         out_age;
    logic               last_of_run;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [31:0]        name_high;
    logic [7:0]         age;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic rec_t req_to_rec(in_word_t w);
    rec_t r;
    r.key       = w.record_key;
    r.name_low  = w.name_bytes_low;
    r.name_mid  = w.name_bytes_mid;
    r.name_high = w.name_bytes_high;
    r.age       = w.age_value;
    return r;
  endfunction

  function automatic out_word_t make_out(rec_t r, logic [2:0] st, logic last);
    out_word_t o;
    o.status        = st;
    o.out_key       = r.key;
    o.out_name_low  = r.name_low;
    o.out_name_mid  = r.name_mid;
    o.out_name_high = r.name_high;
    o.out_age       = r.age;
    o.last_of_run   = last;
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/krt_ram.sv -----
// ----------------------------------------------------------------------------
// krt_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/keyed_record_table_core.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Packed key/record table with add, find, delete, update and list requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as one word on in_valid/in_ready; results leave as words
//   on out_valid/out_ready. in_ready is high only while the sequencer is idle.
//   Records live in one RAM (one read, one write port, registered read).
//   Key search walks the filled entries one per cycle; delete then compacts
//   the later entries, one entry per cycle. List streams one record per
//   cycle while the output register can take a word, last_of_run set on the
//   final word; an empty table gives one word with status empty.
//   Operation codes 6 and 7 are dropped without a result.
//   A result sits in the output register until taken; the next request may be
//   accepted meanwhile, and the sequencer pauses only when it has a new word
//   and the output register is still full.
//   Reset empties the table (entry count zero); RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire krt_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output krt_pkg::out_word_t      out_word
);

  import krt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_LIST  = 5'b01000,
    S_STAT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  in_word_t            req_r, req_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic                chk_valid_r, chk_valid_nxt;
  logic [2:0]          stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [REC_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [REC_W-1:0]    ram_rdata;

  rec_t                rd_rec;
  rec_t                upd_rec;
  logic                out_free;
  logic                hit;
  logic                more;
  logic                is_last;
  logic                sh_done;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_rec   = rec_t'(ram_rdata);
  assign out_free = !out_valid_r || out_ready;
  assign hit      = chk_valid_r && (rd_rec.key == req_r.record_key);
  assign more     = idx_r < count_r;
  assign is_last  = (CNT_W'(chk_idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    upd_rec = rd_rec;
    if (req_r.operation == OP_UPD_NAME) begin
      upd_rec.name_low  = req_r.name_bytes_low;
      upd_rec.name_mid  = req_r.name_bytes_mid;
      upd_rec.name_high = req_r.name_bytes_high;
    end else if (req_r.operation == OP_UPD_AGE) begin
      upd_rec.age = req_r.age_value;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_valid_nxt = chk_valid_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = chk_idx_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[ADDR_W-1:0];
    sh_done       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt       = in_word;
          idx_nxt       = '0;
          chk_valid_nxt = 1'b0;
          case (in_word.operation)
            OP_ADD, OP_FIND, OP_DELETE: begin
              state_nxt = S_SCAN;
            end
            OP_UPD_NAME, OP_UPD_AGE: begin
              if (in_word.record_key == 32'sd0) begin
                stat_nxt  = ST_NOTFOUND;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_LIST: begin
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (req_r.operation == OP_ADD) begin
            stat_nxt  = ST_DUP;
            state_nxt = S_STAT;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = make_out(upd_rec, ST_OK, 1'b1);
            if (req_r.operation == OP_DELETE) begin
              idx_nxt       = CNT_W'(chk_idx_r) + CNT_W'(1);
              chk_valid_nxt = 1'b0;
              state_nxt     = S_SHIFT;
            end else begin
              ram_we    = (req_r.operation == OP_UPD_NAME) ||
                          (req_r.operation == OP_UPD_AGE);
              ram_wdata = upd_rec;
              state_nxt = S_IDLE;
            end
          end
        end else if (more) begin
          ram_re        = 1'b1;
          chk_idx_nxt   = idx_r[ADDR_W-1:0];
          chk_valid_nxt = 1'b1;
          idx_nxt       = idx_r + CNT_W'(1);
        end else if (req_r.operation == OP_ADD) begin
          if (count_r == CNT_W'(CAPACITY)) begin
            stat_nxt  = ST_FULL;
            state_nxt = S_STAT;
          end else if (out_free) begin
            ram_we        = 1'b1;
            ram_waddr     = count_r[ADDR_W-1:0];
            ram_wdata     = req_to_rec(req_r);
            out_valid_nxt = 1'b1;
            out_word_nxt  = make_out(req_to_rec(req_r), ST_OK, 1'b1);
            count_nxt     = count_r + CNT_W'(1);
            state_nxt     = S_IDLE;
          end
        end else begin
          stat_nxt  = ST_NOTFOUND;
          state_nxt = S_STAT;
        end
      end

      S_SHIFT: begin
        if (chk_valid_r) begin
          ram_we      = 1'b1;
          ram_waddr   = chk_idx_r;
          ram_wdata   = ram_rdata;
          chk_idx_nxt = chk_idx_r + ADDR_W'(1);
        end
        if (more) begin
          ram_re        = 1'b1;
          chk_valid_nxt = 1'b1;
          idx_nxt       = idx_r + CNT_W'(1);
        end else begin
          chk_valid_nxt = 1'b0;
          if (!chk_valid_r) begin
            sh_done   = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_IDLE;
          end
        end
      end

      S_LIST: begin
        if (chk_valid_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = make_out(rd_rec, ST_OK, is_last);
          chk_valid_nxt = 1'b0;
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
        if ((!chk_valid_r || out_free) && more) begin
          ram_re        = 1'b1;
          chk_idx_nxt   = idx_r[ADDR_W-1:0];
          chk_valid_nxt = 1'b1;
          idx_nxt       = idx_r + CNT_W'(1);
        end
      end

      S_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = make_out('0, stat_r, 1'b1);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    stat_r     <= stat_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN || state_r == S_SHIFT))
    else $error("RAM write outside scan or compaction");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && ram_we) |-> (CNT_W'(ram_waddr) + CNT_W'(1) < count_r))
    else $error("compaction write beyond filled entries");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    sh_done |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not drop entry count");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed record table core.
// Requests come from a pending queue and are driven on in_valid/in_ready.
// Every accepted request is applied to a local copy of the table, and the
// words it should produce are queued. Each result word is compared field by
// field with the oldest queued word. A directed pass hits the boundary keys,
// every operation and the duplicate, not-found and empty refusals. Random
// passes then mix all operations, fill the table past capacity and delete
// fill keys again, under three sender/receiver idle patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import krt_pkg::*;

  localparam logic [2:0]         OP_RSVD_A = 3'd6;
  localparam logic [2:0]         OP_RSVD_B = 3'd7;
  localparam logic signed [31:0] KEY_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX   = 32'sh7fff_ffff;
  localparam int                 POOL_N    = 16;
  localparam int                 FILL_N    = 64;
  localparam int                 WDOG_MAX  = 20000;
  localparam int                 DRAIN_CYC = 300;
  localparam int                 PRINT_MAX = 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  keyed_record_table_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  in_word_t          pending_requests[$];
  out_word_t         expected_results[$];
  rec_t              table_recs[CAPACITY];
  int                rec_count;
  logic signed [31:0] key_pool[POOL_N];
  logic signed [31:0] fill_keys[FILL_N];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int request_count;
  int result_count;
  int longest_list;
  int status_seen[5];
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic out_word_t status_word(logic [2:0] st);
    out_word_t o;
    o             = '0;
    o.status      = st;
    o.last_of_run = 1'b1;
    return o;
  endfunction

  function automatic out_word_t record_word(rec_t r, logic last);
    out_word_t o;
    o.status        = ST_OK;
    o.out_key       = r.key;
    o.out_name_low  = r.name_low;
    o.out_name_mid  = r.name_mid;
    o.out_name_high = r.name_high;
    o.out_age       = r.age;
    o.last_of_run   = last;
    return o;
  endfunction

  // table update and expected words for one accepted request
  task automatic apply_request(in_word_t w);
    int   slot;
    rec_t r;
    slot = -1;
    for (int i = 0; i < rec_count; i++)
      if (slot < 0 && table_recs[i].key == w.record_key) slot = i;
    case (w.operation)
      OP_ADD: begin
        if (slot >= 0) begin
          expected_results.push_back(status_word(ST_DUP));
        end else if (rec_count == CAPACITY) begin
          expected_results.push_back(status_word(ST_FULL));
        end else begin
          r.key                 = w.record_key;
          r.name_low            = w.name_bytes_low;
          r.name_mid            = w.name_bytes_mid;
          r.name_high           = w.name_bytes_high;
          r.age                 = w.age_value;
          table_recs[rec_count] = r;
          rec_count++;
          expected_results.push_back(record_word(r, 1'b1));
        end
      end
      OP_FIND: begin
        if (slot < 0) expected_results.push_back(status_word(ST_NOTFOUND));
        else expected_results.push_back(record_word(table_recs[slot], 1'b1));
      end
      OP_DELETE: begin
        if (slot < 0) begin
          expected_results.push_back(status_word(ST_NOTFOUND));
        end else begin
          expected_results.push_back(record_word(table_recs[slot], 1'b1));
          for (int i = slot; i < rec_count - 1; i++) table_recs[i] = table_recs[i + 1];
          rec_count--;
        end
      end
      OP_UPD_NAME, OP_UPD_AGE: begin
        if (slot < 0 || w.record_key == 0) begin
          expected_results.push_back(status_word(ST_NOTFOUND));
        end else begin
          if (w.operation == OP_UPD_NAME) begin
            table_recs[slot].name_low  = w.name_bytes_low;
            table_recs[slot].name_mid  = w.name_bytes_mid;
            table_recs[slot].name_high = w.name_bytes_high;
          end else begin
            table_recs[slot].age = w.age_value;
          end
          expected_results.push_back(record_word(table_recs[slot], 1'b1));
        end
      end
      OP_LIST: begin
        if (rec_count == 0) expected_results.push_back(status_word(ST_EMPTY));
        for (int i = 0; i < rec_count; i++)
          expected_results.push_back(record_word(table_recs[i], i == rec_count - 1));
        if (rec_count > longest_list) longest_list = rec_count;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_MAX)
      $display("[%0t] MISMATCH word %0d %s: got %h expected %h",
               $realtime, result_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (got.status < 5) status_seen[got.status]++;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected word, status", 64'(got.status), 64'd0);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.out_key !== want.out_key)
        report_mismatch("key", 64'(got.out_key), 64'(want.out_key));
      if (got.out_name_low !== want.out_name_low)
        report_mismatch("name low", got.out_name_low, want.out_name_low);
      if (got.out_name_mid !== want.out_name_mid)
        report_mismatch("name mid", got.out_name_mid, want.out_name_mid);
      if (got.out_name_high !== want.out_name_high)
        report_mismatch("name high", 64'(got.out_name_high), 64'(want.out_name_high));
      if (got.out_age !== want.out_age)
        report_mismatch("age", 64'(got.out_age), 64'(want.out_age));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last", 64'(got.last_of_run), 64'(want.last_of_run));
    end
    result_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_word);
        request_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_word);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic queue_req(logic [2:0] op, logic signed [31:0] key, logic [63:0] lo,
                           logic [63:0] mid, logic [31:0] hi, logic [7:0] age);
    in_word_t w;
    w.operation       = op;
    w.record_key      = key;
    w.name_bytes_low  = lo;
    w.name_bytes_mid  = mid;
    w.name_bytes_high = hi;
    w.age_value       = age;
    pending_requests.push_back(w);
  endtask

  task automatic queue_rand(logic [2:0] op, logic signed [31:0] key);
    queue_req(op, key, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
              8'($urandom_range(255)));
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_N - 1)];
    return $urandom;
  endfunction

  // one random pass: mixed traffic, fill past capacity, then mostly deletes
  task automatic queue_random_pass();
    int roll;
    for (int i = 0; i < 25; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) queue_rand(OP_ADD, pick_key());
      else if (roll < 50) queue_rand(OP_FIND, pick_key());
      else if (roll < 65) queue_rand(OP_DELETE, pick_key());
      else if (roll < 78) queue_rand(OP_UPD_NAME, pick_key());
      else if (roll < 91) queue_rand(OP_UPD_AGE, pick_key());
      else queue_rand(OP_LIST, pick_key());
      if ($urandom_range(99) < 4)
        queue_rand($urandom_range(1) ? OP_RSVD_A : OP_RSVD_B, pick_key());
    end
    for (int i = 0; i < FILL_N; i++) begin
      fill_keys[i] = $urandom;
      queue_rand(OP_ADD, fill_keys[i]);
      if ($urandom_range(99) < 8) begin
        roll = $urandom_range(2);
        queue_rand(roll == 0 ? OP_FIND : roll == 1 ? OP_UPD_NAME : OP_UPD_AGE,
                   fill_keys[$urandom_range(i)]);
      end
    end
    queue_rand(OP_LIST, pick_key());
    queue_rand(OP_ADD, $urandom);
    queue_rand(OP_ADD, fill_keys[$urandom_range(FILL_N - 1)]);
    for (int i = 0; i < 22; i++) begin
      roll = $urandom_range(99);
      if (roll < 70) queue_rand(OP_DELETE, fill_keys[$urandom_range(FILL_N - 1)]);
      else if (roll < 82) queue_rand(OP_FIND, fill_keys[$urandom_range(FILL_N - 1)]);
      else if (roll < 90) queue_rand(OP_UPD_NAME, fill_keys[$urandom_range(FILL_N - 1)]);
      else if (roll < 95) queue_rand(OP_UPD_AGE, pick_key());
      else queue_rand(OP_LIST, pick_key());
    end
  endtask

  task automatic wait_pending_empty();
    while (pending_requests.size() > 0 || in_valid) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 63;
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    longest_list  = 0;
    rec_count     = 0;
    quiet_cycles  = 0;
    status_seen   = '{default: 0};
    key_pool[0] = 0;
    key_pool[1] = KEY_MIN;
    key_pool[2] = KEY_MAX;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < POOL_N; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    queue_rand(OP_LIST, 0);
    queue_rand(OP_FIND, 5);
    queue_rand(OP_DELETE, 5);
    queue_req(OP_ADD, KEY_MIN, '1, '1, '1, 8'hff);
    queue_req(OP_ADD, KEY_MAX, '0, '0, '0, 8'h00);
    queue_rand(OP_ADD, 0);
    queue_rand(OP_ADD, -1);
    queue_rand(OP_ADD, KEY_MIN);
    queue_rand(OP_FIND, KEY_MAX);
    queue_rand(OP_FIND, 0);
    queue_rand(OP_UPD_NAME, 0);
    queue_rand(OP_UPD_AGE, 0);
    queue_rand(OP_UPD_NAME, KEY_MIN);
    queue_req(OP_UPD_AGE, -1, '0, '0, '0, 8'h00);
    queue_rand(OP_UPD_AGE, 12345);
    queue_rand(OP_RSVD_A, 0);
    queue_rand(OP_RSVD_B, KEY_MAX);
    queue_rand(OP_LIST, 0);
    queue_rand(OP_DELETE, KEY_MIN);
    queue_rand(OP_DELETE, 0);
    queue_rand(OP_DELETE, -1);
    queue_rand(OP_DELETE, 0);
    queue_rand(OP_LIST, 0);
    queue_rand(OP_DELETE, KEY_MAX);
    queue_rand(OP_LIST, 0);

    queue_random_pass();
    wait_pending_empty();
    send_idle_pct <= 63;
    recv_idle_pct <= 7;
    queue_random_pass();
    wait_pending_empty();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random_pass();
    wait_pending_empty();

    while (expected_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("covered %0d requests and %0d result words, longest list %0d records",
             request_count, result_count, longest_list);
    $display("status mix: ok %0d, duplicate %0d, not found %0d, full %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
